// ----- design/sbe_pkg.sv -----
// Shared types, constants and opcode tables for the stack bytecode executor.
// No dependencies; used by the top level, sbe_front and sbe_back.
package sbe_pkg;

  localparam int STACK_DEPTH   = 4096;
  localparam int GLOBALS_DEPTH = 256;
  localparam int ARRAY_DEPTH   = 1024;
  localparam int CODE_DEPTH    = 4096;

  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int CNT_W   = STK_AW + 1;
  localparam int GLB_AW  = $clog2(GLOBALS_DEPTH);
  localparam int ARR_AW  = $clog2(ARRAY_DEPTH);
  localparam int FP_W    = 13;
  localparam int ACELL_W = 11;
  localparam int CFG_W   = 13;

  // Configuration register indexes
  localparam logic REG_PROG_LEN    = 1'b0;
  localparam logic REG_ARRAY_CELLS = 1'b1;

  // Opcodes
  localparam logic [4:0] OP_PUSH   = 5'd0;
  localparam logic [4:0] OP_POP    = 5'd1;
  localparam logic [4:0] OP_LOAD   = 5'd2;
  localparam logic [4:0] OP_GSTORE = 5'd3;
  localparam logic [4:0] OP_ADD    = 5'd4;
  localparam logic [4:0] OP_SUB    = 5'd5;
  localparam logic [4:0] OP_MUL    = 5'd6;
  localparam logic [4:0] OP_DIV    = 5'd7;
  localparam logic [4:0] OP_MOD    = 5'd8;
  localparam logic [4:0] OP_EQ     = 5'd9;
  localparam logic [4:0] OP_NE     = 5'd10;
  localparam logic [4:0] OP_LT     = 5'd11;
  localparam logic [4:0] OP_LTE    = 5'd12;
  localparam logic [4:0] OP_GT     = 5'd13;
  localparam logic [4:0] OP_GTE    = 5'd14;
  localparam logic [4:0] OP_AND    = 5'd15;
  localparam logic [4:0] OP_OR     = 5'd16;
  localparam logic [4:0] OP_NOT    = 5'd17;
  localparam logic [4:0] OP_NEG    = 5'd18;
  localparam logic [4:0] OP_JMP    = 5'd19;
  localparam logic [4:0] OP_JMPIF  = 5'd20;
  localparam logic [4:0] OP_ALOAD  = 5'd21;
  localparam logic [4:0] OP_ASTORE = 5'd22;
  localparam logic [4:0] OP_EMIT   = 5'd23;
  localparam logic [4:0] OP_PRSTR  = 5'd24;
  localparam logic [4:0] OP_HALT   = 5'd25;

  // Status codes
  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_HALT   = 3'd1;
  localparam logic [2:0] STS_OVF    = 3'd2;
  localparam logic [2:0] STS_UNF    = 3'd3;
  localparam logic [2:0] STS_BOUNDS = 3'd4;
  localparam logic [2:0] STS_BADOP  = 3'd5;
  localparam logic [2:0] STS_BADGLB = 3'd6;
  localparam logic [2:0] STS_END    = 3'd7;

  // Print kinds
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_INT  = 2'd1;
  localparam logic [1:0] PK_STR  = 2'd2;

  // Classified instruction handed from front to back
  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] imm;
    logic [1:0]  npop;
    logic        npush;
    logic        bad_op;
    logic        glob_op;
  } item_t;

  function automatic logic [1:0] pop_count(input logic [4:0] op);
    logic [1:0] n;
    unique case (op)
      OP_PUSH, OP_LOAD, OP_JMP, OP_PRSTR, OP_HALT:      n = 2'd0;
      OP_POP, OP_GSTORE, OP_NOT, OP_NEG, OP_JMPIF,
      OP_EMIT:                                          n = 2'd1;
      OP_ASTORE:                                        n = 2'd3;
      default:                                          n = 2'd2;
    endcase
    return n;
  endfunction

  function automatic logic push_count(input logic [4:0] op);
    logic n;
    unique case (op)
      OP_POP, OP_GSTORE, OP_JMP, OP_JMPIF, OP_ASTORE,
      OP_EMIT, OP_PRSTR, OP_HALT:                       n = 1'b0;
      default:                                          n = 1'b1;
    endcase
    return n;
  endfunction

endpackage

// ----- design/stack_bytecode_executor.sv -----
// Stack bytecode executor: one instruction per input beat, one result beat each.
// Each instruction passes IDLE, then RD and RDW per popped operand, then EXEC,
// MEMW for a global or in-bounds array load or DIV for div/mod, then WB and OUT;
// faults and stopped-machine beats go from IDLE straight to OUT. A new instruction
// is taken only after the previous result is registered. Reset is asynchronous;
// afterwards a sweep zeroes the array pool before the first instruction executes.
// Depends on sbe_pkg, sbe_front, sbe_back.
module stack_bytecode_executor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [sbe_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [4:0]                 operation_i,
  input  logic [31:0]                immediate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [12:0]                next_fetch_o,
  output logic [1:0]                 print_kind_o,
  output logic [31:0]                print_value_o,
  output logic [2:0]                 status_o,
  output logic                       stopped_o
);

  logic [sbe_pkg::CFG_W-1:0]   plen_q;
  logic [sbe_pkg::ACELL_W-1:0] acells_q;
  logic                        hd_valid, hd_take;
  sbe_pkg::item_t              hd_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= '0;
      acells_q <= sbe_pkg::ACELL_W'(1024);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sbe_pkg::REG_PROG_LEN) begin
        plen_q <= cfg_data_i;
      end else begin
        acells_q <= cfg_data_i[sbe_pkg::ACELL_W-1:0];
      end
    end
  end

  sbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .immediate_i (immediate_i),
    .hd_valid_o  (hd_valid),
    .hd_item_o   (hd_item),
    .hd_take_i   (hd_take)
  );

  sbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .prog_len_i    (plen_q),
    .acells_i      (acells_q),
    .hd_valid_i    (hd_valid),
    .hd_item_i     (hd_item),
    .hd_take_o     (hd_take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .next_fetch_o  (next_fetch_o),
    .print_kind_o  (print_kind_o),
    .print_value_o (print_value_o),
    .status_o      (status_o),
    .stopped_o     (stopped_o)
  );

endmodule

// ----- design/sbe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sbe_div.sv -----
// Iterative signed divide/modulo unit, one quotient bit per cycle.
// No dependencies.
module sbe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        want_mod_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic        busy_q, done_q, na_q, nb_q, mod_q, zero_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, mb_q;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, mb_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring shift-subtract datapath on magnitudes
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      na_q   <= a_i[31];
      nb_q   <= b_i[31];
      mod_q  <= want_mod_i;
      zero_q <= (b_i == 32'd0);
      quo_q  <= a_i[31] ? (32'd0 - a_i) : a_i;
      mb_q   <= b_i[31] ? (32'd0 - b_i) : b_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  // Sign fix-up; zero divisor gives zero
  always_comb begin
    if (zero_q) begin
      res_o = '0;
    end else if (mod_q) begin
      res_o = na_q ? (32'd0 - rem_q) : rem_q;
    end else begin
      res_o = (na_q ^ nb_q) ? (32'd0 - quo_q) : quo_q;
    end
  end

  assign done_o = done_q;

endmodule

// ----- design/sbe_front.sv -----
// Front end: accepts instruction beats, classifies them, holds a two-entry queue.
// Depends on sbe_pkg.
module sbe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [4:0]      operation_i,
  input  logic [31:0]     immediate_i,
  output logic            hd_valid_o,
  output sbe_pkg::item_t  hd_item_o,
  input  logic            hd_take_i
);

  sbe_pkg::item_t slot_q [2];
  logic [1:0]     cnt_q;
  logic           wr_q, rd_q;
  logic           push, pop;
  sbe_pkg::item_t cls;

  // Classification
  always_comb begin
    cls.op      = operation_i;
    cls.imm     = immediate_i;
    cls.npop    = sbe_pkg::pop_count(operation_i);
    cls.npush   = sbe_pkg::push_count(operation_i);
    cls.bad_op  = (operation_i > sbe_pkg::OP_HALT);
    cls.glob_op = (operation_i == sbe_pkg::OP_LOAD) || (operation_i == sbe_pkg::OP_GSTORE);
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign hd_valid_o = (cnt_q != 2'd0);
  assign pop        = hd_take_i && hd_valid_o;
  assign hd_item_o  = slot_q[rd_q];

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cls;
    end
  end

endmodule

// ----- design/sbe_back.sv -----
// Back end: executes classified instructions against stack, globals and arrays.
// Depends on sbe_pkg, sbe_ram and sbe_div.
module sbe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sbe_pkg::CFG_W-1:0]   prog_len_i,
  input  logic [sbe_pkg::ACELL_W-1:0] acells_i,
  input  logic                        hd_valid_i,
  input  sbe_pkg::item_t              hd_item_i,
  output logic                        hd_take_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [12:0]                 next_fetch_o,
  output logic [1:0]                  print_kind_o,
  output logic [31:0]                 print_value_o,
  output logic [2:0]                  status_o,
  output logic                        stopped_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_MEMW = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam int CNT_W  = sbe_pkg::CNT_W;
  localparam int STK_AW = sbe_pkg::STK_AW;
  localparam int GLB_AW = sbe_pkg::GLB_AW;
  localparam int ARR_AW = sbe_pkg::ARR_AW;
  localparam int FP_W   = sbe_pkg::FP_W;
  localparam int ACELL_W_L = sbe_pkg::ACELL_W;

  logic [2:0]                   state_q;
  sbe_pkg::item_t               itm_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [FP_W-1:0]              fp_q;
  logic                         stopped_q;
  logic [2:0]                   stopc_q;
  logic [1:0]                   k_q;
  logic [31:0]                  opa_q, opb_q, opc_q, wval_q;
  logic                         inb_q;
  logic [ARR_AW-1:0]            addr_q;
  logic [sbe_pkg::GLOBALS_DEPTH-1:0] gvld_q;
  logic [ARR_AW:0]              clr_q;
  logic [1:0]                   rkind_q;
  logic [31:0]                  rpval_q;
  logic [2:0]                   rsts_q;
  logic                         ovalid_q, ostop_q;
  logic [FP_W-1:0]              ofp_q;
  logic [1:0]                   okind_q;
  logic [31:0]                  opval_q;
  logic [2:0]                   osts_q;

  logic                         clearing;
  logic [FP_W-1:0]              len, fp_inc, jtgt, nfp;
  logic [ACELL_W_L-1:0]         abound;
  logic [CNT_W:0]               depth_after;
  logic [2:0]                   fsts;
  logic [CNT_W-1:0]             rd_idx, wr_idx;
  logic [31:0]                  asum, alu;
  logic                         ainb, start, out_free, jump;
  logic [31:0]                  stk_rd, glb_rd, arr_rd, div_res;
  logic                         div_done, div_start;
  logic                         stk_we, glb_we, arr_we;
  logic [ARR_AW-1:0]            arr_waddr;
  logic [31:0]                  arr_wdata;

  // Effective limits
  assign len = (prog_len_i > FP_W'(sbe_pkg::CODE_DEPTH)) ? FP_W'(sbe_pkg::CODE_DEPTH)
                                                          : prog_len_i;
  assign abound = (acells_i > ACELL_W_L'(sbe_pkg::ARRAY_DEPTH))
                  ? ACELL_W_L'(sbe_pkg::ARRAY_DEPTH) : acells_i;
  assign fp_inc = fp_q + 13'd1;
  assign jtgt   = (itm_q.imm < {{(32-FP_W){1'b0}}, len}) ? itm_q.imm[FP_W-1:0] : len;
  assign jump   = (itm_q.op == sbe_pkg::OP_JMP) ||
                  ((itm_q.op == sbe_pkg::OP_JMPIF) && (opb_q == 32'd0));
  assign nfp    = jump ? jtgt : fp_inc;

  assign clearing = !clr_q[ARR_AW];
  assign start    = (state_q == S_IDLE) && hd_valid_i && !clearing;
  assign hd_take_o = start;
  assign out_free = !ovalid_q || !out_stall_i;

  // Fault check on the queue head: bad opcode, bad global, underflow, overflow
  assign depth_after = {1'b0, cnt_q} - (CNT_W+1)'(hd_item_i.npop)
                       + (CNT_W+1)'(hd_item_i.npush);
  always_comb begin
    if (hd_item_i.bad_op) begin
      fsts = sbe_pkg::STS_BADOP;
    end else if (hd_item_i.glob_op && (hd_item_i.imm >= 32'(sbe_pkg::GLOBALS_DEPTH))) begin
      fsts = sbe_pkg::STS_BADGLB;
    end else if (cnt_q < CNT_W'(hd_item_i.npop)) begin
      fsts = sbe_pkg::STS_UNF;
    end else if (depth_after > (CNT_W+1)'(sbe_pkg::STACK_DEPTH)) begin
      fsts = sbe_pkg::STS_OVF;
    end else begin
      fsts = sbe_pkg::STS_OK;
    end
  end

  // Stack addressing
  assign rd_idx = cnt_q - CNT_W'(k_q) - CNT_W'(1);
  assign wr_idx = cnt_q - CNT_W'(itm_q.npop);

  // Array address and bound
  assign asum = opa_q + opb_q;
  assign ainb = asum < {{(32-ACELL_W_L){1'b0}}, abound};

  // Combinational ALU for the operations computed in EXEC
  always_comb begin
    unique case (itm_q.op)
      sbe_pkg::OP_PUSH:  alu = itm_q.imm;
      sbe_pkg::OP_ADD:   alu = opa_q + opb_q;
      sbe_pkg::OP_SUB:   alu = opa_q - opb_q;
      sbe_pkg::OP_MUL:   alu = opa_q * opb_q;
      sbe_pkg::OP_EQ:    alu = {31'd0, opa_q == opb_q};
      sbe_pkg::OP_NE:    alu = {31'd0, opa_q != opb_q};
      sbe_pkg::OP_LT:    alu = {31'd0, $signed(opa_q) <  $signed(opb_q)};
      sbe_pkg::OP_LTE:   alu = {31'd0, $signed(opa_q) <= $signed(opb_q)};
      sbe_pkg::OP_GT:    alu = {31'd0, $signed(opa_q) >  $signed(opb_q)};
      sbe_pkg::OP_GTE:   alu = {31'd0, $signed(opa_q) >= $signed(opb_q)};
      sbe_pkg::OP_AND:   alu = {31'd0, (opa_q != 32'd0) && (opb_q != 32'd0)};
      sbe_pkg::OP_OR:    alu = {31'd0, (opa_q != 32'd0) || (opb_q != 32'd0)};
      sbe_pkg::OP_NOT:   alu = {31'd0, opb_q == 32'd0};
      sbe_pkg::OP_NEG:   alu = 32'd0 - opb_q;
      default:           alu = 32'd0;
    endcase
  end

  // Memory control
  assign stk_we    = (state_q == S_WB) && itm_q.npush;
  assign glb_we    = (state_q == S_WB) && (itm_q.op == sbe_pkg::OP_GSTORE);
  assign arr_we    = clearing ||
                     ((state_q == S_WB) && (itm_q.op == sbe_pkg::OP_ASTORE) && inb_q);
  assign arr_waddr = clearing ? clr_q[ARR_AW-1:0] : addr_q;
  assign arr_wdata = clearing ? 32'd0 : opc_q;
  assign div_start = (state_q == S_EXEC) &&
                     ((itm_q.op == sbe_pkg::OP_DIV) || (itm_q.op == sbe_pkg::OP_MOD));

  sbe_ram #(.WIDTH(32), .DEPTH(sbe_pkg::STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (wr_idx[STK_AW-1:0]),
    .wdata_i (wval_q),
    .raddr_i (rd_idx[STK_AW-1:0]),
    .rdata_o (stk_rd)
  );

  sbe_ram #(.WIDTH(32), .DEPTH(sbe_pkg::GLOBALS_DEPTH)) u_glob (
    .clk_i   (clk_i),
    .we_i    (glb_we),
    .waddr_i (itm_q.imm[GLB_AW-1:0]),
    .wdata_i (opb_q),
    .raddr_i (itm_q.imm[GLB_AW-1:0]),
    .rdata_o (glb_rd)
  );

  sbe_ram #(.WIDTH(32), .DEPTH(sbe_pkg::ARRAY_DEPTH)) u_arr (
    .clk_i   (clk_i),
    .we_i    (arr_we),
    .waddr_i (arr_waddr),
    .wdata_i (arr_wdata),
    .raddr_i (asum[ARR_AW-1:0]),
    .rdata_o (arr_rd)
  );

  sbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .want_mod_i (itm_q.op == sbe_pkg::OP_MOD),
    .a_i        (opa_q),
    .b_i        (opb_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // Sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      fp_q      <= '0;
      stopped_q <= 1'b0;
      stopc_q   <= sbe_pkg::STS_OK;
      k_q       <= '0;
      gvld_q    <= '0;
      clr_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (clearing) clr_q <= clr_q + (ARR_AW+1)'(1);

      // Result beat: set when loaded, dropped once taken
      if (state_q == S_OUT && out_free) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            if (stopped_q) begin
              state_q <= S_OUT;
            end else if (fp_q >= len) begin
              stopped_q <= 1'b1;
              stopc_q   <= sbe_pkg::STS_END;
              state_q   <= S_OUT;
            end else if (fsts != sbe_pkg::STS_OK) begin
              fp_q      <= fp_inc;
              stopped_q <= 1'b1;
              stopc_q   <= fsts;
              state_q   <= S_OUT;
            end else begin
              k_q     <= '0;
              state_q <= (hd_item_i.npop != 2'd0) ? S_RD : S_EXEC;
            end
          end
        end
        S_RD:   state_q <= S_RDW;
        S_RDW: begin
          k_q     <= k_q + 2'd1;
          state_q <= ((k_q + 2'd1) == itm_q.npop) ? S_EXEC : S_RD;
        end
        S_EXEC: begin
          if (itm_q.op == sbe_pkg::OP_LOAD ||
              (itm_q.op == sbe_pkg::OP_ALOAD && ainb)) begin
            state_q <= S_MEMW;
          end else if (div_start) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_WB;
          end
        end
        S_MEMW: state_q <= S_WB;
        S_DIV:  if (div_done) state_q <= S_WB;
        S_WB: begin
          cnt_q <= cnt_q - CNT_W'(itm_q.npop) + CNT_W'(itm_q.npush);
          fp_q  <= nfp;
          if (glb_we) gvld_q[itm_q.imm[GLB_AW-1:0]] <= 1'b1;
          if (rsts_q == sbe_pkg::STS_HALT) begin
            stopped_q <= 1'b1;
            stopc_q   <= sbe_pkg::STS_HALT;
          end else if (nfp >= len) begin
            stopped_q <= 1'b1;
            stopc_q   <= sbe_pkg::STS_END;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        itm_q   <= hd_item_i;
        rkind_q <= sbe_pkg::PK_NONE;
        rpval_q <= '0;
        if (stopped_q) begin
          rsts_q <= stopc_q;
        end else if (fp_q >= len) begin
          rsts_q <= sbe_pkg::STS_END;
        end else begin
          rsts_q <= fsts;
        end
      end
      S_RDW: begin
        unique case (k_q)
          2'd0:    opb_q <= stk_rd;
          2'd1:    opa_q <= stk_rd;
          default: opc_q <= stk_rd;
        endcase
      end
      S_EXEC: begin
        wval_q <= alu;
        addr_q <= asum[ARR_AW-1:0];
        inb_q  <= ainb;
        if ((itm_q.op == sbe_pkg::OP_ALOAD || itm_q.op == sbe_pkg::OP_ASTORE) && !ainb) begin
          rsts_q <= sbe_pkg::STS_BOUNDS;
        end
        if (itm_q.op == sbe_pkg::OP_HALT) rsts_q <= sbe_pkg::STS_HALT;
        if (itm_q.op == sbe_pkg::OP_EMIT) begin
          rkind_q <= sbe_pkg::PK_INT;
          rpval_q <= opb_q;
        end
        if (itm_q.op == sbe_pkg::OP_PRSTR) begin
          rkind_q <= sbe_pkg::PK_STR;
          rpval_q <= itm_q.imm;
        end
      end
      S_MEMW: begin
        if (itm_q.op == sbe_pkg::OP_LOAD) begin
          wval_q <= gvld_q[itm_q.imm[GLB_AW-1:0]] ? glb_rd : 32'd0;
        end else begin
          wval_q <= arr_rd;
        end
      end
      S_DIV: if (div_done) wval_q <= div_res;
      S_WB: begin
        if (rsts_q == sbe_pkg::STS_OK && nfp >= len) rsts_q <= sbe_pkg::STS_END;
      end
      S_OUT: begin
        if (out_free) begin
          ofp_q   <= fp_q;
          okind_q <= rkind_q;
          opval_q <= rpval_q;
          osts_q  <= rsts_q;
          ostop_q <= stopped_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = ovalid_q;
  assign next_fetch_o  = ofp_q;
  assign print_kind_o  = okind_q;
  assign print_value_o = opval_q;
  assign status_o      = osts_q;
  assign stopped_o     = ostop_q;

endmodule
